FILE: sv/bbc_pkg.sv
// bbc_pkg: shared types and constants of the blue blob centroid block
// pixel and result payloads, sequencer states, divider status, register indexes
// no dependencies
package bbc_pkg;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd240;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 4;

  // frame size is divided by this to get the blob area threshold
  localparam int BLOB_DIV = 20;

  localparam int COLOR_W  = 8;
  localparam int CENTER_W = 14;
  localparam int COUNT_W  = 21;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic                found;
    logic [CENTER_W-1:0] x_center_q4;
    logic [CENTER_W-1:0] y_center_q4;
    logic [COUNT_W-1:0]  blue_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV_W,
    ST_DIV_H,
    ST_MUL,
    ST_CMP,
    ST_DIV_X,
    ST_DIV_Y,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/bbc_div.sv
// bbc_div: restoring divider, one quotient bit per cycle
// depends on bbc_pkg (div_sts_t)
module bbc_div #(
  parameter int DVD_W = 35,
  parameter int DVS_W = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output bbc_pkg::div_sts_t    sts
);

  localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // shift in the next dividend bit, trial subtract
  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      q_nxt   = {q_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: sv/blue_blob_centroid.sv
// blue_blob_centroid: centroid of the blue pixels of a raster frame, on bbc_pkg and bbc_div
// a pixel request is taken while accumulating; the last pixel of a frame starts the frame-end sequence
// and input stalls until its result is loaded: 4 threshold steps (w/20, h/20 by reciprocal,
// product, compare), two centroid divides on bbc_div (dividend width D = 35 at defaults), 1 load
// step; with no blob both divides are skipped, and the load waits while a waiting result is stalled
// synchronous active-low reset clears position, count and sums and sets the size to 320 x 240
module blue_blob_centroid #(
  parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbc_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bbc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bbc_pkg::pixel_t               in_data,
  // frame results
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbc_pkg::result_t              out_data,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbc_pkg::CFG_W-1:0]     cfg_wdata
);

  // position and accumulator widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUMX_W = CNT_W + COL_W;
  localparam int SUMY_W = CNT_W + ROW_W;
  localparam int SUM_W  = (SUMX_W > SUMY_W) ? SUMX_W : SUMY_W;
  // shared divider: dividend carries the fraction bits, divisor is the hit count
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int DVS_W  = CNT_W;
  // threshold factors (size / BLOB_DIV) and their product
  localparam int QWW    = (MAX_WIDTH / bbc_pkg::BLOB_DIV > 0) ?
                          $clog2(MAX_WIDTH / bbc_pkg::BLOB_DIV + 1) : 1;
  localparam int QWH    = (MAX_HEIGHT / bbc_pkg::BLOB_DIV > 0) ?
                          $clog2(MAX_HEIGHT / bbc_pkg::BLOB_DIV + 1) : 1;
  localparam int THR_W  = QWW + QWH;
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
  // size / BLOB_DIV as a multiply by a rounded-up reciprocal, exact for sizes below 16399
  localparam int DIM_W  = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
  localparam int RCP_SH = 16;
  localparam int RCP    = (2 ** RCP_SH + bbc_pkg::BLOB_DIV - 1) / bbc_pkg::BLOB_DIV;
  localparam int RCP_W  = $clog2(RCP + 1);
  localparam int PROD_W = DIM_W + RCP_W;
  // size clamp compare widths
  localparam int XW     = (bbc_pkg::CFG_W > COL_W) ? bbc_pkg::CFG_W : COL_W;
  localparam int YW     = (bbc_pkg::CFG_W > ROW_W) ? bbc_pkg::CFG_W : ROW_W;
  localparam logic [XW:0] MAXW_X = (XW+1)'(MAX_WIDTH);
  localparam logic [YW:0] MAXH_X = (YW+1)'(MAX_HEIGHT);

  // configuration registers
  logic [bbc_pkg::CFG_W-1:0] cfg_w_r, cfg_w_nxt;
  logic [bbc_pkg::CFG_W-1:0] cfg_h_r, cfg_h_nxt;

  // control state
  bbc_pkg::state_t  state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [SUMX_W-1:0] sumx_r, sumx_nxt;
  logic [SUMY_W-1:0] sumy_r, sumy_nxt;
  logic             issued_r, issued_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [QWW-1:0]      wq_r, wq_nxt;
  logic [QWH-1:0]      hq_r, hq_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic                found_r, found_nxt;
  logic [bbc_pkg::CENTER_W-1:0] xc_r, xc_nxt;
  logic [bbc_pkg::CENTER_W-1:0] yc_r, yc_nxt;
  bbc_pkg::result_t    out_data_r, out_data_nxt;

  // effective frame size, zero taken as one and clamped to the maximum
  logic [XW:0]      w_cfg_x;
  logic [YW:0]      h_cfg_x;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [COL_W:0]   w_eff;
  logic [ROW_W:0]   h_eff;

  // reciprocal multiply for the threshold factors, shared by width and height
  logic [DIM_W-1:0]         rcp_in;
  logic [PROD_W-1:0]        rcp_prod;
  logic [PROD_W-RCP_SH-1:0] rcp_q;

  // pixel path
  logic in_acc;
  logic is_blue;
  logic line_end;
  logic frame_end;

  // shared divider
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_q;
  bbc_pkg::div_sts_t div_sts;

  assign w_cfg_x = (XW+1)'(cfg_w_r);
  assign h_cfg_x = (YW+1)'(cfg_h_r);
  assign wm1 = (cfg_w_r == '0) ? '0 :
               (w_cfg_x > MAXW_X) ? COL_W'(MAX_WIDTH - 1) : COL_W'(w_cfg_x - 1'b1);
  assign hm1 = (cfg_h_r == '0) ? '0 :
               (h_cfg_x > MAXH_X) ? ROW_W'(MAX_HEIGHT - 1) : ROW_W'(h_cfg_x - 1'b1);
  assign w_eff = {1'b0, wm1} + 1'b1;
  assign h_eff = {1'b0, hm1} + 1'b1;

  // width in the width step, height in the height step
  assign rcp_in   = (state_r == bbc_pkg::ST_DIV_H) ? DIM_W'(h_eff) : DIM_W'(w_eff);
  assign rcp_prod = PROD_W'(rcp_in) * PROD_W'(RCP);
  assign rcp_q    = rcp_prod[PROD_W-1:RCP_SH];

  // pixels are taken only while accumulating; never during reset
  assign in_stall = !rst_n || (state_r != bbc_pkg::ST_ACCUM);
  assign in_acc   = in_valid && !in_stall;

  // strictly bluer than both other channels
  assign is_blue   = (in_data.blue > in_data.green) && (in_data.blue > in_data.red);
  // a position already past a shrunken size ends the line or frame at once
  assign line_end  = col_r >= wm1;
  assign frame_end = line_end && (row_r >= hm1);

  // divider operands follow the sequencer state
  always_comb begin
    case (state_r)
      bbc_pkg::ST_DIV_X: begin
        div_dvd = DVD_W'(sumx_r) << FRAC_BITS;
        div_dvs = hit_cnt_r;
      end
      default: begin
        div_dvd = DVD_W'(sumy_r) << FRAC_BITS;
        div_dvs = hit_cnt_r;
      end
    endcase
  end

  bbc_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // configuration decode; a new size takes effect at once
  always_comb begin
    cfg_w_nxt = cfg_w_r;
    cfg_h_nxt = cfg_h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bbc_pkg::REG_FRAME_WIDTH:  cfg_w_nxt = cfg_wdata;
        bbc_pkg::REG_FRAME_HEIGHT: cfg_h_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: accumulate pixels, then at frame end threshold, centroid divides if a blob is found, and result load
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    hit_cnt_nxt   = hit_cnt_r;
    sumx_nxt      = sumx_r;
    sumy_nxt      = sumy_r;
    issued_nxt    = issued_r;
    wq_nxt        = wq_r;
    hq_nxt        = hq_r;
    thr_nxt       = thr_r;
    found_nxt     = found_r;
    xc_nxt        = xc_r;
    yc_nxt        = yc_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    // a waiting result leaves when the far side takes it
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      bbc_pkg::ST_ACCUM: begin
        if (in_acc) begin
          if (is_blue) begin
            hit_cnt_nxt = hit_cnt_r + 1'b1;
            sumx_nxt    = sumx_r + SUMX_W'(col_r);
            sumy_nxt    = sumy_r + SUMY_W'(row_r);
          end
          if (frame_end) begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = bbc_pkg::ST_DIV_W;
          end else if (line_end) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end

      bbc_pkg::ST_DIV_W: begin
        // width / BLOB_DIV
        wq_nxt    = rcp_q[QWW-1:0];
        state_nxt = bbc_pkg::ST_DIV_H;
      end

      bbc_pkg::ST_DIV_H: begin
        // height / BLOB_DIV
        hq_nxt    = rcp_q[QWH-1:0];
        state_nxt = bbc_pkg::ST_MUL;
      end

      bbc_pkg::ST_MUL: begin
        // blob area threshold, registered before the compare
        thr_nxt   = THR_W'(wq_r) * THR_W'(hq_r);
        state_nxt = bbc_pkg::ST_CMP;
      end

      bbc_pkg::ST_CMP: begin
        found_nxt = CMP_W'(hit_cnt_r) > CMP_W'(thr_r);
        // no blob: skip both centroid divides
        state_nxt = (CMP_W'(hit_cnt_r) > CMP_W'(thr_r)) ? bbc_pkg::ST_DIV_X
                                                        : bbc_pkg::ST_OUT;
      end

      bbc_pkg::ST_DIV_X: begin
        if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_sts.done) begin
          issued_nxt = 1'b0;
          xc_nxt     = div_q[bbc_pkg::CENTER_W-1:0];
          state_nxt  = bbc_pkg::ST_DIV_Y;
        end
      end

      bbc_pkg::ST_DIV_Y: begin
        if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_sts.done) begin
          issued_nxt = 1'b0;
          yc_nxt     = div_q[bbc_pkg::CENTER_W-1:0];
          state_nxt  = bbc_pkg::ST_OUT;
        end
      end

      bbc_pkg::ST_OUT: begin
        // wait for the output register, then load the result and clear the frame accumulators
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.found       = found_r;
          out_data_nxt.x_center_q4 = found_r ? xc_r : '0;
          out_data_nxt.y_center_q4 = found_r ? yc_r : '0;
          out_data_nxt.blue_count  = bbc_pkg::COUNT_W'(hit_cnt_r);
          out_valid_nxt            = 1'b1;
          hit_cnt_nxt              = '0;
          sumx_nxt                 = '0;
          sumy_nxt                 = '0;
          state_nxt                = bbc_pkg::ST_ACCUM;
        end
      end

      default: begin
        state_nxt = bbc_pkg::ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbc_pkg::ST_ACCUM;
      cfg_w_r     <= bbc_pkg::FRAME_WIDTH_RST;
      cfg_h_r     <= bbc_pkg::FRAME_HEIGHT_RST;
      col_r       <= '0;
      row_r       <= '0;
      hit_cnt_r   <= '0;
      sumx_r      <= '0;
      sumy_r      <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      sumx_r      <= sumx_nxt;
      sumy_r      <= sumy_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wq_r       <= wq_nxt;
    hq_r       <= hq_nxt;
    thr_r      <= thr_nxt;
    found_r    <= found_nxt;
    xc_r       <= xc_nxt;
    yc_r       <= yc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // divider completions belong to a divide step of the sequencer
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == bbc_pkg::ST_DIV_X || state_r == bbc_pkg::ST_DIV_Y))
    else $error("divider finished outside a divide step");

  // a new result only comes from the output step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bbc_pkg::ST_OUT))
    else $error("result raised outside the output step");

  // no blob means zero centroid
  a_no_blob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.x_center_q4 == '0 && out_data_r.y_center_q4 == '0))
    else $error("centroid reported without a blob");

endmodule
